### rtl/core/vic_pkg.sv
`timescale 1ns / 1ps

package vic_pkg;

   localparam int NUM_SOURCES_DEF = 11;
   localparam int WORD_W          = 32;
   localparam int OP_W            = 2;
   localparam int IDX_W           = 4;
   localparam int SID_W           = 4;
   localparam int VEC_W           = 4;
   localparam logic [VEC_W-1:0] NO_VECTOR = 4'hF;

   typedef enum logic [OP_W-1:0] {
      OP_READ     = 2'd0,
      OP_WRITE    = 2'd1,
      OP_ASSERT   = 2'd2,
      OP_DEASSERT = 2'd3
   } op_type;

   localparam logic [IDX_W-1:0] REG_CTRL   = 4'd0;
   localparam logic [IDX_W-1:0] REG_NIMASK = 4'd1;
   localparam logic [IDX_W-1:0] REG_EN_NUM = 4'd2;
   localparam logic [IDX_W-1:0] REG_DIS_NUM = 4'd3;
   localparam logic [IDX_W-1:0] REG_ENABLE = 4'd4;
   localparam logic [IDX_W-1:0] REG_TYPE   = 4'd5;
   localparam logic [IDX_W-1:0] REG_FORCE  = 4'd6;
   localparam logic [IDX_W-1:0] REG_NIVEC  = 4'd7;
   localparam logic [IDX_W-1:0] REG_FIVEC  = 4'd8;
   localparam logic [IDX_W-1:0] REG_SRC    = 4'd9;
   localparam logic [IDX_W-1:0] REG_NIPEND = 4'd10;
   localparam logic [IDX_W-1:0] REG_FIPEND = 4'd11;

   typedef struct packed {
      op_type             op;
      logic [IDX_W-1:0]   idx;
      logic [WORD_W-1:0]  data;
      logic [SID_W-1:0]   sid;
      logic               err;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } push_type;

   typedef struct packed {
      logic    avail;
      cmd_type cmd;
   } head_type;

endpackage

### rtl/core/vic_front.sv
`timescale 1ns / 1ps

module vic_front (
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [vic_pkg::OP_W-1:0]    req_operation,
   input  logic [vic_pkg::IDX_W-1:0]   req_reg_index,
   input  logic [vic_pkg::WORD_W-1:0]  req_write_data,
   input  logic [vic_pkg::SID_W-1:0]   req_source_id,
   input  logic                        queue_full,
   output vic_pkg::push_type           push
);
   import vic_pkg::*;

   logic rd_err;
   logic wr_err;

   always_comb begin
      rd_err = (req_reg_index == REG_EN_NUM) || (req_reg_index == REG_DIS_NUM);
      wr_err = (req_reg_index == REG_NIVEC) || (req_reg_index == REG_FIVEC) ||
               (req_reg_index == REG_SRC) || (req_reg_index == REG_NIPEND) ||
               (req_reg_index == REG_FIPEND);
   end

   assign req_stall = queue_full;

   always_comb begin
      push.push     = req_valid && !queue_full;
      push.cmd.op   = op_type'(req_operation);
      push.cmd.idx  = req_reg_index;
      push.cmd.data = req_write_data;
      push.cmd.sid  = req_source_id;
      case (op_type'(req_operation))
         OP_READ:  push.cmd.err = rd_err;
         OP_WRITE: push.cmd.err = wr_err;
         default:  push.cmd.err = 1'b0;
      endcase
   end

endmodule

### rtl/core/vic_queue.sv
`timescale 1ns / 1ps

module vic_queue (
   input  logic               clock,
   input  logic               reset,
   input  vic_pkg::push_type  push,
   input  logic               pop,
   output logic               full,
   output vic_pkg::head_type  head
);
   import vic_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_pop;

   assign full       = (count_ff == 2'd2);
   assign head.avail = (count_ff != 2'd0);
   assign head.cmd   = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head.avail;

   always_comb begin
      wr_ptr_in = push.push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push.push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push.push && do_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push) begin
         slot_ff[wr_ptr_ff] <= push.cmd;
      end
   end

endmodule

### rtl/core/vic_back.sv
`timescale 1ns / 1ps

module vic_back #(
   parameter int NUM_SOURCES = vic_pkg::NUM_SOURCES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  vic_pkg::head_type           head,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [vic_pkg::WORD_W-1:0]  rsp_read_data,
   output logic                        rsp_access_error,
   output logic                        rsp_fiq_line,
   output logic                        rsp_irq_line
);
   import vic_pkg::*;

   logic [WORD_W-1:0]      ctrl_ff, ctrl_in;
   logic [WORD_W-1:0]      nimask_ff, nimask_in;
   logic [WORD_W-1:0]      enable_ff, enable_in;
   logic [WORD_W-1:0]      type_ff, type_in;
   logic [WORD_W-1:0]      force_ff, force_in;
   logic [NUM_SOURCES-1:0] src_ff, src_in;
   logic [NUM_SOURCES-1:0] npend_ff, npend_in;
   logic [NUM_SOURCES-1:0] fpend_ff, fpend_in;
   logic [VEC_W-1:0]       nvec_ff, nvec_in;
   logic [VEC_W-1:0]       fvec_ff, fvec_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]      rdata_ff, rdata_in;
   logic                   err_ff, err_in;
   logic                   fiq_ff, fiq_in;
   logic                   irq_ff, irq_in;

   logic                   take;
   logic                   do_pop;
   logic                   recompute;
   logic [NUM_SOURCES-1:0] act;
   logic [NUM_SOURCES-1:0] nkeep;
   logic [WORD_W-1:0]      num_bit;
   cmd_type                cmd;

   function automatic logic [VEC_W-1:0] top_source(input logic [NUM_SOURCES-1:0] bits);
      logic [VEC_W-1:0] v;
      v = NO_VECTOR;
      for (int i = 0; i < NUM_SOURCES; i++) begin
         if (bits[i]) v = VEC_W'(i);
      end
      return v;
   endfunction

   assign cmd    = head.cmd;
   assign take   = !rsp_valid_ff || !rsp_stall;
   assign pop    = take;
   assign do_pop = take && head.avail;

   always_comb begin
      ctrl_in   = ctrl_ff;
      nimask_in = nimask_ff;
      enable_in = enable_ff;
      type_in   = type_ff;
      force_in  = force_ff;
      src_in    = src_ff;
      recompute = 1'b0;
      num_bit   = WORD_W'(1) << cmd.data[4:0];
      rdata_in  = '0;
      case (cmd.op)
         OP_READ: begin
            case (cmd.idx)
               REG_CTRL:   rdata_in = ctrl_ff;
               REG_NIMASK: rdata_in = nimask_ff;
               REG_ENABLE: rdata_in = enable_ff;
               REG_TYPE:   rdata_in = type_ff;
               REG_FORCE:  rdata_in = force_ff;
               REG_NIVEC:  rdata_in = WORD_W'(nvec_ff);
               REG_FIVEC:  rdata_in = WORD_W'(fvec_ff);
               REG_SRC:    rdata_in = WORD_W'(src_ff);
               REG_NIPEND: rdata_in = WORD_W'(npend_ff);
               REG_FIPEND: rdata_in = WORD_W'(fpend_ff);
               default:    rdata_in = '0;
            endcase
         end
         OP_WRITE: begin
            recompute = 1'b1;
            case (cmd.idx)
               REG_CTRL:    ctrl_in   = cmd.data;
               REG_NIMASK:  nimask_in = cmd.data;
               REG_EN_NUM: begin
                  if (cmd.data[WORD_W-1:5] == '0) enable_in = enable_ff | num_bit;
               end
               REG_DIS_NUM: begin
                  if (cmd.data[WORD_W-1:5] == '0) enable_in = enable_ff & ~num_bit;
               end
               REG_ENABLE:  enable_in = cmd.data;
               REG_TYPE:    type_in   = cmd.data;
               REG_FORCE:   force_in  = cmd.data;
               default: ;
            endcase
         end
         default: begin
            recompute = 1'b1;
            for (int i = 0; i < NUM_SOURCES; i++) begin
               if (cmd.sid == SID_W'(i)) src_in[i] = (cmd.op == OP_ASSERT);
            end
         end
      endcase

      act = src_in & enable_in[NUM_SOURCES-1:0];
      for (int i = 0; i < NUM_SOURCES; i++) begin
         nkeep[i] = (nimask_in >= WORD_W'(NUM_SOURCES)) || (WORD_W'(i) > nimask_in);
      end

      if (recompute) begin
         fpend_in = act & type_in[NUM_SOURCES-1:0];
         npend_in = act & ~type_in[NUM_SOURCES-1:0] & nkeep;
         fvec_in  = top_source(fpend_in);
         nvec_in  = top_source(npend_in);
      end else begin
         fpend_in = fpend_ff;
         npend_in = npend_ff;
         fvec_in  = fvec_ff;
         nvec_in  = nvec_ff;
      end

      err_in       = cmd.err;
      fiq_in       = (fpend_in != '0);
      irq_in       = !fiq_in && (npend_in != '0);
      rsp_valid_in = do_pop ? 1'b1 : (take ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff      <= '0;
         nimask_ff    <= '0;
         enable_ff    <= '0;
         type_ff      <= '0;
         force_ff     <= '0;
         src_ff       <= '0;
         npend_ff     <= '0;
         fpend_ff     <= '0;
         nvec_ff      <= '0;
         fvec_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (do_pop) begin
            ctrl_ff   <= ctrl_in;
            nimask_ff <= nimask_in;
            enable_ff <= enable_in;
            type_ff   <= type_in;
            force_ff  <= force_in;
            src_ff    <= src_in;
            npend_ff  <= npend_in;
            fpend_ff  <= fpend_in;
            nvec_ff   <= nvec_in;
            fvec_ff   <= fvec_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_pop) begin
         rdata_ff <= rdata_in;
         err_ff   <= err_in;
         fiq_ff   <= fiq_in;
         irq_ff   <= irq_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rdata_ff;
   assign rsp_access_error = err_ff;
   assign rsp_fiq_line     = fiq_ff;
   assign rsp_irq_line     = irq_ff;

endmodule

### rtl/core/vectored_interrupt_controller.sv
`timescale 1ns / 1ps

// Vectored interrupt controller with fast (fiq) and normal (irq) request lines.
// Each request word is a register read, a register write, a source assert or a
// source deassert, and each gives exactly one response word carrying read data,
// an access error flag and the fiq and irq levels after that word. One word is
// accepted per cycle while the queue is not full; the word waits in a queue
// slot and its response is registered, and can be taken when the response
// side is not stalled. A two-word queue separates request decode from the
// execute stage, where the register update, pending mask recompute and both
// priority encoders are combinational. No clearing pass is needed after reset.

module vectored_interrupt_controller #(
   parameter int NUM_SOURCES = vic_pkg::NUM_SOURCES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [vic_pkg::OP_W-1:0]    req_operation,
   input  logic [vic_pkg::IDX_W-1:0]   req_reg_index,
   input  logic [vic_pkg::WORD_W-1:0]  req_write_data,
   input  logic [vic_pkg::SID_W-1:0]   req_source_id,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [vic_pkg::WORD_W-1:0]  rsp_read_data,
   output logic                        rsp_access_error,
   output logic                        rsp_fiq_line,
   output logic                        rsp_irq_line
);
   import vic_pkg::*;

   push_type push;
   head_type head;
   logic     queue_full;
   logic     pop;

   vic_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_reg_index  (req_reg_index),
      .req_write_data (req_write_data),
      .req_source_id  (req_source_id),
      .queue_full     (queue_full),
      .push           (push)
   );

   vic_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   vic_back #(
      .NUM_SOURCES (NUM_SOURCES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data),
      .rsp_access_error (rsp_access_error),
      .rsp_fiq_line     (rsp_fiq_line),
      .rsp_irq_line     (rsp_irq_line)
   );

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
   import vic_pkg::*;

   localparam int NS           = NUM_SOURCES_DEF;
   localparam int SCRIPT_LEN   = 25;
   localparam int RANDOM_WORDS = 500;
   localparam int QUIET_LIMIT  = 2000;

   typedef struct packed {
      logic [WORD_W-1:0] read_data;
      logic              access_error;
      logic              fiq_line;
      logic              irq_line;
   } reply_type;

   typedef struct packed {
      op_type            op;
      logic [IDX_W-1:0]  idx;
      logic [WORD_W-1:0] data;
      logic [SID_W-1:0]  sid;
      logic              fixed;
      reply_type         reply;
   } vic_word_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [OP_W-1:0]     req_operation = '0;
   logic [IDX_W-1:0]    req_reg_index = '0;
   logic [WORD_W-1:0]   req_write_data = '0;
   logic [SID_W-1:0]    req_source_id = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [WORD_W-1:0]   rsp_read_data;
   logic                rsp_access_error;
   logic                rsp_fiq_line;
   logic                rsp_irq_line;

   int                  send_gap_pct = 7;
   int                  rsp_stall_pct = 57;
   int unsigned         mismatches = 0;
   int unsigned         quiet_cycles = 0;
   reply_type           due_replies[$];

   // controller state as seen through the register file
   logic [WORD_W-1:0]   ctrl_r = '0;
   logic [WORD_W-1:0]   nimask_r = '0;
   logic [WORD_W-1:0]   enable_r = '0;
   logic [WORD_W-1:0]   type_r = '0;
   logic [WORD_W-1:0]   force_r = '0;
   logic [NS-1:0]       src_r = '0;
   logic [NS-1:0]       npend_r = '0;
   logic [NS-1:0]       fpend_r = '0;
   logic [VEC_W-1:0]    nvec_r = '0;
   logic [VEC_W-1:0]    fvec_r = '0;

   vic_word_type script [SCRIPT_LEN] = '{
      '{OP_READ,     REG_NIVEC,   32'h0,        4'd0,  1'b1, '{32'h0, 1'b0, 1'b0, 1'b0}},
      '{OP_READ,     REG_EN_NUM,  32'h0,        4'd0,  1'b1, '{32'h0, 1'b1, 1'b0, 1'b0}},
      '{OP_READ,     REG_DIS_NUM, 32'h0,        4'd0,  1'b1, '{32'h0, 1'b1, 1'b0, 1'b0}},
      '{OP_READ,     4'd15,       32'h0,        4'd0,  1'b1, '{32'h0, 1'b0, 1'b0, 1'b0}},
      '{OP_WRITE,    REG_CTRL,    32'hFFFFFFFF, 4'd0,  1'b1, '{32'h0, 1'b0, 1'b0, 1'b0}},
      '{OP_READ,     REG_CTRL,    32'h0,        4'd0,  1'b1,
        '{32'hFFFFFFFF, 1'b0, 1'b0, 1'b0}},
      '{OP_WRITE,    REG_FORCE,   32'hA5A5A5A5, 4'd0,  1'b1, '{32'h0, 1'b0, 1'b0, 1'b0}},
      '{OP_READ,     REG_FORCE,   32'h0,        4'd0,  1'b1,
        '{32'hA5A5A5A5, 1'b0, 1'b0, 1'b0}},
      '{OP_WRITE,    REG_NIVEC,   32'h00001234, 4'd0,  1'b1, '{32'h0, 1'b1, 1'b0, 1'b0}},
      '{OP_WRITE,    REG_FIPEND,  32'hFFFFFFFF, 4'd0,  1'b1, '{32'h0, 1'b1, 1'b0, 1'b0}},
      '{OP_WRITE,    4'd12,       32'hFFFFFFFF, 4'd0,  1'b1, '{32'h0, 1'b0, 1'b0, 1'b0}},
      '{OP_READ,     REG_FIVEC,   32'h0,        4'd0,  1'b1, '{32'hF, 1'b0, 1'b0, 1'b0}},
      '{OP_WRITE,    REG_EN_NUM,  32'd0,        4'd0,  1'b0, '0},
      '{OP_WRITE,    REG_EN_NUM,  32'd32,       4'd0,  1'b0, '0},
      '{OP_WRITE,    REG_EN_NUM,  32'd31,       4'd0,  1'b0, '0},
      '{OP_ASSERT,   REG_CTRL,    32'h0,        4'd0,  1'b0, '0},
      '{OP_ASSERT,   REG_CTRL,    32'h0,        4'd15, 1'b0, '0},
      '{OP_WRITE,    REG_ENABLE,  32'hFFFFFFFF, 4'd0,  1'b0, '0},
      '{OP_ASSERT,   REG_CTRL,    32'h0,        4'd10, 1'b0, '0},
      '{OP_WRITE,    REG_NIMASK,  32'hFFFFFFFF, 4'd0,  1'b0, '0},
      '{OP_READ,     REG_NIPEND,  32'h0,        4'd0,  1'b0, '0},
      '{OP_WRITE,    REG_TYPE,    32'h00000400, 4'd0,  1'b0, '0},
      '{OP_READ,     REG_FIVEC,   32'h0,        4'd0,  1'b0, '0},
      '{OP_WRITE,    REG_DIS_NUM, 32'd10,       4'd0,  1'b0, '0},
      '{OP_DEASSERT, REG_CTRL,    32'h0,        4'd0,  1'b0, '0}
   };

   vectored_interrupt_controller dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_reg_index    (req_reg_index),
      .req_write_data   (req_write_data),
      .req_source_id    (req_source_id),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data),
      .rsp_access_error (rsp_access_error),
      .rsp_fiq_line     (rsp_fiq_line),
      .rsp_irq_line     (rsp_irq_line)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [VEC_W-1:0] top_pending(logic [NS-1:0] bits);
      for (int n = NS - 1; n >= 0; n--) begin
         if (bits[n]) return n[VEC_W-1:0];
      end
      return NO_VECTOR;
   endfunction

   function automatic void refresh_pending();
      logic [NS-1:0] act;
      act = src_r & enable_r[NS-1:0];
      fpend_r = act & type_r[NS-1:0];
      npend_r = act & ~type_r[NS-1:0];
      if (nimask_r < NS) begin
         for (int n = 0; n < NS; n++) begin
            if (n <= nimask_r) npend_r[n] = 1'b0;
         end
      end
      nvec_r = top_pending(npend_r);
      fvec_r = top_pending(fpend_r);
   endfunction

   function automatic reply_type controller_step(vic_word_type w);
      reply_type r;
      r = '0;
      case (w.op)
         OP_READ: begin
            case (w.idx)
               REG_CTRL:                 r.read_data = ctrl_r;
               REG_NIMASK:               r.read_data = nimask_r;
               REG_EN_NUM, REG_DIS_NUM:  r.access_error = 1'b1;
               REG_ENABLE:               r.read_data = enable_r;
               REG_TYPE:                 r.read_data = type_r;
               REG_FORCE:                r.read_data = force_r;
               REG_NIVEC:                r.read_data = WORD_W'(nvec_r);
               REG_FIVEC:                r.read_data = WORD_W'(fvec_r);
               REG_SRC:                  r.read_data = WORD_W'(src_r);
               REG_NIPEND:               r.read_data = WORD_W'(npend_r);
               REG_FIPEND:               r.read_data = WORD_W'(fpend_r);
               default: ;
            endcase
         end
         OP_WRITE: begin
            case (w.idx)
               REG_CTRL:   ctrl_r = w.data;
               REG_NIMASK: nimask_r = w.data;
               REG_EN_NUM: if (w.data < WORD_W) enable_r[w.data[4:0]] = 1'b1;
               REG_DIS_NUM: if (w.data < WORD_W) enable_r[w.data[4:0]] = 1'b0;
               REG_ENABLE: enable_r = w.data;
               REG_TYPE:   type_r = w.data;
               REG_FORCE:  force_r = w.data;
               REG_NIVEC, REG_FIVEC, REG_SRC, REG_NIPEND, REG_FIPEND:
                  r.access_error = 1'b1;
               default: ;
            endcase
            refresh_pending();
         end
         default: begin
            if (w.sid < NS) src_r[w.sid] = (w.op == OP_ASSERT);
            refresh_pending();
         end
      endcase
      r.fiq_line = |fpend_r;
      r.irq_line = !r.fiq_line && (|npend_r);
      return r;
   endfunction

   // mostly in-range indexes and source numbers, with some out of range
   function automatic vic_word_type random_word();
      vic_word_type w;
      int pick;
      w = '0;
      pick = $urandom_range(99);
      if (pick < 30) w.op = OP_READ;
      else if (pick < 65) w.op = OP_WRITE;
      else if (pick < 85) w.op = OP_ASSERT;
      else w.op = OP_DEASSERT;
      if ($urandom_range(99) < 90) w.idx = IDX_W'($urandom_range(REG_FIPEND));
      else w.idx = IDX_W'($urandom_range(15, 12));
      if ($urandom_range(99) < 85) w.sid = SID_W'($urandom_range(NS - 1));
      else w.sid = SID_W'($urandom_range(15, NS));
      w.data = $urandom();
      if ($urandom_range(99) < 80) begin
         case (w.idx)
            REG_EN_NUM, REG_DIS_NUM: w.data = $urandom_range(WORD_W - 1);
            REG_NIMASK:              w.data = $urandom_range(NS + 1);
            default: ;
         endcase
      end
      return w;
   endfunction

   task automatic send_word(vic_word_type w);
      reply_type r;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= w.op;
      req_reg_index  <= w.idx;
      req_write_data <= w.data;
      req_source_id  <= w.sid;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      r = controller_step(w);
      due_replies.push_back(w.fixed ? w.reply : r);
   endtask

   always @(posedge clock) begin : reply_check
      reply_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_replies.size() == 0) begin
               $error("reply word with nothing outstanding");
               mismatches++;
            end else begin
               want = due_replies.pop_front();
               if (rsp_read_data !== want.read_data) begin
                  $error("read_data: expected %h, got %h", want.read_data, rsp_read_data);
                  mismatches++;
               end
               if (rsp_access_error !== want.access_error) begin
                  $error("access_error: expected %b, got %b",
                         want.access_error, rsp_access_error);
                  mismatches++;
               end
               if (rsp_fiq_line !== want.fiq_line) begin
                  $error("fiq_line: expected %b, got %b", want.fiq_line, rsp_fiq_line);
                  mismatches++;
               end
               if (rsp_irq_line !== want.irq_line) begin
                  $error("irq_line: expected %b, got %b", want.irq_line, rsp_irq_line);
                  mismatches++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < SCRIPT_LEN; i++) send_word(script[i]);
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               send_gap_pct = 7;
               rsp_stall_pct = 57;
            end
            1: begin
               send_gap_pct = 57;
               rsp_stall_pct = 7;
            end
            default: begin
               send_gap_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         // hold off until every reply is back
         req_valid <= 1'b0;
         while (due_replies.size() != 0) @(posedge clock);
         for (int k = 0; k < RANDOM_WORDS / 3; k++) send_word(random_word());
      end
      req_valid <= 1'b0;
      while (due_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
